/* rtl/pph_pkg.sv */
// Shared types and constants for the pulse period histogram.
// Used by the front, back and top modules in rtl/; no dependencies.
package pph_pkg;

    localparam int CMD_W       = 2;
    localparam int STAMP_W     = 32;
    localparam int SEL_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 10;
    localparam int PERIOD_W    = 14;
    localparam int SEEN_W      = 10;
    localparam int LIMIT_W     = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_RECORDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 14'd1000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 10'd1023;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 14'd16383;
    localparam int                  WINDOW_OFFSET = 50;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_INC   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [STATUS_W-1:0]   status;
        logic [PERIOD_W-1:0]   period;
        logic [SEEN_W-1:0]     seen;
        logic                  done;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
        logic [PERIOD_W-1:0]   period;
        logic [SEEN_W-1:0]     seen;
        logic                  done;
    } res_t;

endpackage

/* rtl/pph_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read.
// No package dependencies.
module pph_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pph_fifo.sv */
// Small synchronous queue with full/empty flags.
// No package dependencies; used between the front, back and output side.
module pph_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/pph_front.sv */
// Front end: decodes commands, tracks the capture run and classifies intervals.
// Depends on pph_pkg.
module pph_front #(
    parameter int NUM_BINS   = 100,
    parameter int RUN_LENGTH = 1000,
    parameter int ADDR_W     = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [pph_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic                          accept,
    input  logic [pph_pkg::CMD_W-1:0]     command,
    input  logic [pph_pkg::STAMP_W-1:0]   timestamp,
    input  logic [pph_pkg::SEL_W-1:0]     bin_index,
    output pph_pkg::op_t                  op,
    output logic [ADDR_W-1:0]             addr
);

    localparam int CNT_W = $clog2(RUN_LENGTH + 1);
    localparam int REL_W = pph_pkg::STAMP_W + 2;
    localparam int SUM_W = pph_pkg::LIMIT_W + 1;

    logic [pph_pkg::LIMIT_W-1:0] limit_reg;
    logic [pph_pkg::STAMP_W-1:0] prev_reg, prev_next;
    logic                        have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]            total_reg, total_next;

    logic [pph_pkg::STAMP_W-1:0] diff;
    logic [REL_W-1:0]            rel;
    logic                        in_win;
    logic [SUM_W-1:0]            psum, pdiff;
    logic [pph_pkg::PERIOD_W-1:0] period;
    logic [ADDR_W+pph_pkg::SEL_W-1:0] sel_ext;
    logic                        sel_ok;

    assign diff   = timestamp - prev_reg;
    assign rel    = {2'b00, diff} + REL_W'(pph_pkg::WINDOW_OFFSET)
                    - {{(REL_W - pph_pkg::LIMIT_W){1'b0}}, limit_reg};
    assign in_win = !rel[REL_W-1] && (rel < REL_W'(NUM_BINS));

    // Bin period is limit - offset + index, clamped to the field range.
    assign psum  = {1'b0, limit_reg} + SUM_W'(bin_index);
    assign pdiff = psum - SUM_W'(pph_pkg::WINDOW_OFFSET);
    always_comb
    begin
        if (psum < SUM_W'(pph_pkg::WINDOW_OFFSET))
        begin
            period = '0;
        end
        else if (pdiff[SUM_W-1])
        begin
            period = pph_pkg::PERIOD_MAX;
        end
        else
        begin
            period = pdiff[pph_pkg::PERIOD_W-1:0];
        end
    end

    assign sel_ext = {ADDR_W'(0), bin_index};
    assign sel_ok  = (32'(bin_index) < 32'(NUM_BINS));

    always_comb
    begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        total_next     = total_reg;
        op.kind        = pph_pkg::OP_NONE;
        op.status      = pph_pkg::ST_RECORDED;
        op.period      = '0;
        addr           = '0;
        unique case (command)
            pph_pkg::CMD_CAPTURE:
            begin
                if (total_reg >= CNT_W'(RUN_LENGTH))
                begin
                    op.status = pph_pkg::ST_DONE;
                end
                else if (!have_prev_reg)
                begin
                    have_prev_next = 1'b1;
                    prev_next      = timestamp;
                    total_next     = total_reg + 1'b1;
                    op.status      = pph_pkg::ST_FIRST;
                end
                else
                begin
                    prev_next  = timestamp;
                    total_next = total_reg + 1'b1;
                    if (in_win)
                    begin
                        op.kind = pph_pkg::OP_INC;
                        addr    = rel[ADDR_W-1:0];
                    end
                    else
                    begin
                        op.status = pph_pkg::ST_DROPPED;
                    end
                end
            end
            pph_pkg::CMD_CLEAR:
            begin
                have_prev_next = 1'b0;
                prev_next      = '0;
                total_next     = '0;
                op.kind        = pph_pkg::OP_CLEAR;
            end
            pph_pkg::CMD_READ:
            begin
                op.period = period;
                if (sel_ok)
                begin
                    op.kind = pph_pkg::OP_READ;
                    addr    = sel_ext[ADDR_W-1:0];
                end
            end
            default:
            begin
                op.kind = pph_pkg::OP_NONE;
            end
        endcase
        op.seen = pph_pkg::SEEN_W'(total_next);
        op.done = (total_next >= CNT_W'(RUN_LENGTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= pph_pkg::LIMIT_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                prev_reg      <= prev_next;
                have_prev_reg <= have_prev_next;
                total_reg     <= total_next;
            end
        end
    end

endmodule

/* rtl/pph_back.sv */
// Back end: bin read-modify-write with forwarding, per-bin valid bits, reads.
// Depends on pph_pkg and pph_ram.
module pph_back #(
    parameter int NUM_BINS = 100,
    parameter int ADDR_W   = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  pph_pkg::op_t        q_op,
    input  logic [ADDR_W-1:0]   q_addr,
    output logic                q_pop,
    input  logic                o_full,
    output logic                o_push,
    output pph_pkg::res_t       o_res
);

    logic                         s2_valid_reg;
    pph_pkg::op_t                 s2_op_reg;
    logic [ADDR_W-1:0]            s2_addr_reg;
    logic [NUM_BINS-1:0]          bin_valid_reg;
    logic                         fwd_valid_reg;
    logic [ADDR_W-1:0]            fwd_addr_reg;
    logic [pph_pkg::COUNT_W-1:0]  fwd_data_reg;

    logic                         advance;
    logic                         wr_en;
    logic                         fwd_hit;
    logic [pph_pkg::COUNT_W-1:0]  ram_rdata;
    logic [pph_pkg::COUNT_W-1:0]  old_count, cur_count, new_count;

    assign advance = !s2_valid_reg || !o_full;
    assign q_pop   = advance && !q_empty;
    assign o_push  = advance && s2_valid_reg;
    assign wr_en   = o_push && (s2_op_reg.kind == pph_pkg::OP_INC);

    pph_ram #(
        .WIDTH (pph_pkg::COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_addr_reg),
        .wdata (new_count),
        .re    (q_pop),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    // The write of the previous op lands on the same edge as this op's read.
    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s2_addr_reg);
    assign old_count = fwd_hit ? fwd_data_reg : ram_rdata;
    assign cur_count = bin_valid_reg[s2_addr_reg] ? old_count : '0;
    assign new_count = (cur_count == pph_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

    always_comb
    begin
        o_res.status = s2_op_reg.status;
        o_res.period = s2_op_reg.period;
        o_res.seen   = s2_op_reg.seen;
        o_res.done   = s2_op_reg.done;
        o_res.count  = '0;
        case (s2_op_reg.kind)
            pph_pkg::OP_READ: o_res.count = cur_count;
            default:          o_res.count = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            bin_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= !q_empty;
            fwd_valid_reg <= wr_en;
            if (s2_valid_reg && s2_op_reg.kind == pph_pkg::OP_CLEAR)
            begin
                bin_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                bin_valid_reg[s2_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_op_reg   <= q_op;
            s2_addr_reg <= q_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= new_count;
        end
    end

endmodule

/* rtl/pulse_period_histogram.sv */
// Pulse period histogram: bins intervals between timer capture stamps.
// Input queue side: push/full with command, timestamp, bin_index.
// Result queue side: empty/pop with status, bin_count, bin_period,
// captures_seen, run_done; one result per accepted command, in order.
// Config side: cfg_valid/cfg_ready/cfg_data writes lower_limit; cfg_ready
// is always high. Write it only while no command is in flight.
// Throughput: one command per cycle unless the result queue is full. A result
// shows up (empty low) after the command queue, the RAM read into the update
// stage, then the update plus write-back as it enters the result queue.
// Clear empties all bins at once through per-bin valid flags.
// Reset: lower_limit returns to 1000, the run count, previous stamp and all
// bins clear, and both queues empty; no clearing pass is needed.
// When the receiver stalls, results fill the two-entry result queue, one
// more command waits in the update stage, then the two-entry command queue
// fills and full rises.
// Depends on pph_pkg, pph_fifo, pph_front, pph_back, pph_ram.
module pulse_period_histogram #(
    parameter int NUM_BINS   = 100,
    parameter int RUN_LENGTH = 1000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pph_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [pph_pkg::CMD_W-1:0]       command,
    input  logic [pph_pkg::STAMP_W-1:0]     timestamp,
    input  logic [pph_pkg::SEL_W-1:0]       bin_index,
    output logic                            empty,
    input  logic                            pop,
    output logic [pph_pkg::STATUS_W-1:0]    status,
    output logic [pph_pkg::COUNT_W-1:0]     bin_count,
    output logic [pph_pkg::PERIOD_W-1:0]    bin_period,
    output logic [pph_pkg::SEEN_W-1:0]      captures_seen,
    output logic                            run_done
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int OP_W   = $bits(pph_pkg::op_t);
    localparam int Q_W    = OP_W + ADDR_W;
    localparam int RES_W  = $bits(pph_pkg::res_t);

    logic                 accept;
    pph_pkg::op_t         f_op;
    logic [ADDR_W-1:0]    f_addr;
    logic [Q_W-1:0]       q_rdata;
    logic                 q_empty, q_pop;
    logic                 o_full, o_push;
    pph_pkg::res_t        o_res;
    logic [RES_W-1:0]     o_rdata;
    pph_pkg::res_t        head;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    pph_front #(
        .NUM_BINS   (NUM_BINS),
        .RUN_LENGTH (RUN_LENGTH),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .command   (command),
        .timestamp (timestamp),
        .bin_index (bin_index),
        .op        (f_op),
        .addr      (f_addr)
    );

    pph_fifo #(
        .WIDTH (Q_W),
        .DEPTH (pph_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_addr, f_op}),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    pph_back #(
        .NUM_BINS (NUM_BINS),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_op    (pph_pkg::op_t'(q_rdata[OP_W-1:0])),
        .q_addr  (q_rdata[Q_W-1:OP_W]),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_res   (o_res)
    );

    pph_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pph_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_res),
        .full  (o_full),
        .pop   (pop),
        .rdata (o_rdata),
        .empty (empty)
    );

    assign head          = pph_pkg::res_t'(o_rdata);
    assign status        = head.status;
    assign bin_count     = head.count;
    assign bin_period    = head.period;
    assign captures_seen = head.seen;
    assign run_done      = head.done;

endmodule

/* bench/pph_checker.sv */
// Checker for the pulse period histogram: predicts each result and compares it.
// Watches the config, command and result channels of the block; uses pph_pkg.
`timescale 1ns / 1ps

module pph_checker
    import pph_pkg::*;
#(
    parameter int NUM_BINS   = 100,
    parameter int RUN_LENGTH = 1000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_data,
    input  logic                push,
    input  logic                full,
    input  logic [CMD_W-1:0]    command,
    input  logic [STAMP_W-1:0]  timestamp,
    input  logic [SEL_W-1:0]    bin_index,
    input  logic                empty,
    input  logic                pop,
    input  logic [STATUS_W-1:0] status,
    input  logic [COUNT_W-1:0]  bin_count,
    input  logic [PERIOD_W-1:0] bin_period,
    input  logic [SEEN_W-1:0]   captures_seen,
    input  logic                run_done,
    output int                  pending,
    output int                  failures
);

    logic [LIMIT_W-1:0] window_center;
    logic [COUNT_W-1:0] bin_tally [NUM_BINS];
    logic               bin_live [NUM_BINS];
    logic [STAMP_W-1:0] last_edge;
    logic               edge_held;
    int                 edges_taken;
    res_t               awaited_results [$];

    function automatic res_t histogram_step(
        input logic [CMD_W-1:0]   cmd,
        input logic [STAMP_W-1:0] stamp,
        input logic [SEL_W-1:0]   sel
    );
        res_t               r;
        logic [STAMP_W-1:0] gap;
        longint             slot;
        longint             per;
        r = '0;
        case (cmd)
            CMD_CAPTURE:
            begin
                if (edges_taken >= RUN_LENGTH)
                begin
                    r.status = ST_DONE;
                end
                else
                begin
                    if (!edge_held)
                    begin
                        edge_held = 1'b1;
                        r.status  = ST_FIRST;
                    end
                    else
                    begin
                        // interval wraps modulo 2^32
                        gap  = stamp - last_edge;
                        slot = longint'(gap);
                        slot = slot + WINDOW_OFFSET - longint'(window_center);
                        if (slot >= 0 && slot < NUM_BINS)
                        begin
                            if (!bin_live[slot])
                            begin
                                bin_live[slot]  = 1'b1;
                                bin_tally[slot] = COUNT_W'(1);
                            end
                            else if (bin_tally[slot] < COUNT_MAX)
                            begin
                                bin_tally[slot] = bin_tally[slot] + 1'b1;
                            end
                            r.status = ST_RECORDED;
                        end
                        else
                        begin
                            r.status = ST_DROPPED;
                        end
                    end
                    last_edge   = stamp;
                    edges_taken = edges_taken + 1;
                end
            end
            CMD_CLEAR:
            begin
                foreach (bin_live[i]) bin_live[i] = 1'b0;
                edge_held   = 1'b0;
                last_edge   = '0;
                edges_taken = 0;
            end
            CMD_READ:
            begin
                per = longint'(window_center) - WINDOW_OFFSET + longint'(sel);
                if (per < 0) per = 0;
                if (per > longint'(PERIOD_MAX)) per = longint'(PERIOD_MAX);
                r.period = per[PERIOD_W-1:0];
                r.count  = (sel < NUM_BINS && bin_live[sel]) ? bin_tally[sel] : '0;
            end
            default:
            begin
            end
        endcase
        r.seen = edges_taken[SEEN_W-1:0];
        r.done = (edges_taken >= RUN_LENGTH);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        failures = failures + 1;
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_center = LIMIT_RESET;
            foreach (bin_live[i])
            begin
                bin_live[i]  = 1'b0;
                bin_tally[i] = '0;
            end
            last_edge   = '0;
            edge_held   = 1'b0;
            edges_taken = 0;
            failures    = 0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            res_t want;
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result with nothing awaited, captures_seen",
                                    32'(captures_seen), 32'd0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(status), 32'(want.status));
                    compare_field("bin_count", 32'(bin_count), 32'(want.count));
                    compare_field("bin_period", 32'(bin_period), 32'(want.period));
                    compare_field("captures_seen", 32'(captures_seen), 32'(want.seen));
                    compare_field("run_done", 32'(run_done), 32'(want.done));
                end
            end
            if (cfg_valid && cfg_ready)
                window_center = cfg_data;
            if (push && !full)
                awaited_results.push_back(histogram_step(command, timestamp, bin_index));
            pending <= awaited_results.size();
        end
    end

endmodule

/* bench/testbench.sv */
// Top of the pulse period histogram bench: clock, reset, stimulus and verdict.
// Instantiates pulse_period_histogram and pph_checker; uses pph_pkg.
`timescale 1ns / 1ps

module testbench;
    import pph_pkg::*;

    localparam int NUM_BINS   = 100;
    localparam int RUN_LENGTH = 1000;
    localparam int MAX_CYCLES = 400000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data  = '0;
    logic                push      = 1'b0;
    logic                full;
    logic [CMD_W-1:0]    command   = '0;
    logic [STAMP_W-1:0]  timestamp = '0;
    logic [SEL_W-1:0]    bin_index = '0;
    logic                empty;
    logic                pop       = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  bin_count;
    logic [PERIOD_W-1:0] bin_period;
    logic [SEEN_W-1:0]   captures_seen;
    logic                run_done;

    int pending;
    int failures;
    int cycle_count  = 0;
    int send_gap_pct = 20;
    int pop_gap_pct  = 15;
    int hold_left    = 0;

    // stimulus-side view, used only to shape intervals and run length
    int                 cur_limit  = int'(LIMIT_RESET);
    int                 run_caps   = 0;
    logic [STAMP_W-1:0] last_stamp = '0;

    int phase_limit [5] = '{0, 16383, 50, 0, 9950};

    pulse_period_histogram #(
        .NUM_BINS   (NUM_BINS),
        .RUN_LENGTH (RUN_LENGTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .command       (command),
        .timestamp     (timestamp),
        .bin_index     (bin_index),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .bin_count     (bin_count),
        .bin_period    (bin_period),
        .captures_seen (captures_seen),
        .run_done      (run_done)
    );

    pph_checker #(
        .NUM_BINS   (NUM_BINS),
        .RUN_LENGTH (RUN_LENGTH)
    ) i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .command       (command),
        .timestamp     (timestamp),
        .bin_index     (bin_index),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .bin_count     (bin_count),
        .bin_period    (bin_period),
        .captures_seen (captures_seen),
        .run_done      (run_done),
        .pending       (pending),
        .failures      (failures)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: stall pop in bursts at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (pop_gap_pct > 0 && $urandom_range(0, 99) < pop_gap_pct)
        begin
            pop       <= 1'b0;
            hold_left <= $urandom_range(0, 6);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [STAMP_W-1:0] stamp,
                                input logic [SEL_W-1:0] sel);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        push      <= 1'b1;
        command   <= cmd;
        timestamp <= stamp;
        bin_index <= sel;
        do @(posedge clk); while (full);
        if (cmd == CMD_CAPTURE)
        begin
            run_caps   = run_caps + 1;
            last_stamp = stamp;
        end
        else if (cmd == CMD_CLEAR)
        begin
            run_caps = 0;
        end
    endtask

    task automatic random_command(input int capture_pct, input bit allow_clear);
        int                 roll;
        int                 delta;
        logic [CMD_W-1:0]   cmd;
        logic [STAMP_W-1:0] stamp;
        logic [SEL_W-1:0]   sel;
        roll  = $urandom_range(0, 99);
        stamp = $urandom;
        sel   = SEL_W'($urandom_range(0, 127));
        if (roll < capture_pct)
        begin
            cmd = CMD_CAPTURE;
            // mostly land in the window, one tick past each edge included
            if ($urandom_range(0, 9) != 0)
            begin
                delta = int'($urandom_range(0, NUM_BINS + 1)) - 1 + cur_limit - WINDOW_OFFSET;
                stamp = last_stamp + delta;
            end
        end
        else if (roll < capture_pct + (100 - capture_pct) * 3 / 4)
        begin
            cmd = CMD_READ;
            if ($urandom_range(0, 7) != 0)
                sel = SEL_W'($urandom_range(0, NUM_BINS - 1));
        end
        else if (allow_clear && roll < 98)
        begin
            cmd = CMD_CLEAR;
        end
        else
        begin
            cmd = CMD_UNUSED;
        end
        send_command(cmd, stamp, sel);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[LIMIT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = value;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset window covers periods 950..1049
        send_command(CMD_READ, '0, 7'd0);
        send_command(CMD_CAPTURE, 32'd0, 7'd0);
        send_command(CMD_CAPTURE, 32'd950, 7'd0);
        send_command(CMD_CAPTURE, 32'd1999, 7'd0);
        send_command(CMD_CAPTURE, 32'd2948, 7'd0);
        send_command(CMD_CAPTURE, 32'd3998, 7'd0);
        send_command(CMD_CAPTURE, 32'hFFFF_FFFF, 7'd0);
        send_command(CMD_CAPTURE, 32'd999, 7'd0);
        send_command(CMD_READ, '0, 7'd0);
        send_command(CMD_READ, '0, 7'd50);
        send_command(CMD_READ, '0, SEL_W'(NUM_BINS - 1));
        send_command(CMD_READ, 32'hFFFF_FFFF, SEL_W'(NUM_BINS));
        send_command(CMD_READ, '0, 7'd127);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 7'd127);
        send_command(CMD_CLEAR, 32'hFFFF_FFFF, 7'd127);
        send_command(CMD_READ, '0, 7'd50);
        send_command(CMD_CAPTURE, 32'hFFFF_FFFF, 7'd0);
        send_command(CMD_CAPTURE, 32'hFFFF_FFFF, 7'd0);
        send_command(CMD_READ, '0, 7'd50);

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            if (p == 4 || p == 1)
            begin
                send_gap_pct = 0;
                pop_gap_pct  = 0;
            end
            else
            begin
                send_gap_pct = 20;
                pop_gap_pct  = 15;
            end
            write_limit(p == 3 ? int'($urandom_range(50, 9950)) : phase_limit[p]);
            send_command(CMD_CLEAR, $urandom, SEL_W'($urandom));
            send_command(CMD_READ, $urandom, 7'd0);
            send_command(CMD_READ, $urandom, SEL_W'(NUM_BINS - 1));
            send_command(CMD_READ, $urandom, 7'd127);
            // one phase runs to the end of a run and past it
            if (p == 3)
            begin
                while (run_caps < RUN_LENGTH + 5)
                    random_command(96, 1'b0);
            end
            else
            begin
                repeat (16) random_command(70, 1'b1);
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
